// File: hw/rtl/lfo_pkg.sv
// Shared types and constants for the LFO waveform generator.
// Shape and register codes, fill sequencer states, Taylor constants for the sine table.
// No dependencies.
package lfo_pkg;

  localparam int unsigned SINE_DEPTH_DEF = 1024;

  // Q16 levels
  localparam logic [16:0] HALF_LEVEL = 17'd32768;
  localparam logic [16:0] FULL_LEVEL = 17'd65536;

  // Register indexes on the config port
  localparam logic [1:0] CFG_WAVE_SHAPE = 2'd0;
  localparam logic [1:0] CFG_PHASE_INC  = 2'd1;
  localparam logic [1:0] CFG_PHASE_OFS  = 2'd2;
  localparam logic [1:0] CFG_MOD_DEPTH  = 2'd3;

  // Shape codes; anything else plays as sine
  localparam logic [2:0] SHAPE_SINE   = 3'd0;
  localparam logic [2:0] SHAPE_TRI    = 3'd1;
  localparam logic [2:0] SHAPE_SAW    = 3'd2;
  localparam logic [2:0] SHAPE_SQUARE = 3'd3;
  localparam logic [2:0] SHAPE_RANDOM = 3'd4;

  // Register reset values
  localparam logic [31:0] PHASE_INC_RST = 32'd89478;

  // Noise generator
  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  // Q30 constants for the table fill
  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
  localparam logic [47:0] Q30_ROUND   = 48'h0000_2000_0000;

  // Nested Taylor terms, innermost first. Quotient by the divisor is taken as
  // (a * RECIP) >> SHIFT plus at most one correction.
  localparam int unsigned NUM_TERMS = 5;
  localparam logic [6:0] TERM_DIV [NUM_TERMS] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
  localparam logic [5:0] TERM_SHIFT [NUM_TERMS] = '{6'd38, 6'd38, 6'd37, 6'd36, 6'd34};
  localparam logic [31:0] TERM_RECIP [NUM_TERMS] = '{
    32'((64'd1 << 38) / 64'd110),
    32'((64'd1 << 38) / 64'd72),
    32'((64'd1 << 37) / 64'd42),
    32'((64'd1 << 36) / 64'd20),
    32'((64'd1 << 34) / 64'd6)
  };

  typedef enum logic [2:0] {
    FILL_X2,
    FILL_MUL,
    FILL_REC,
    FILL_FIX,
    FILL_S,
    FILL_V,
    FILL_DONE
  } fill_state_e;

  function automatic logic [15:0] lfsr_next(input logic [15:0] cur);
    logic [15:0] nxt;
    nxt = cur >> 1;
    if (cur[0]) begin
      nxt = nxt ^ LFSR_TAPS;
    end
    return nxt;
  endfunction

endpackage

// File: hw/rtl/lfo_waveform_generator.sv
// LFO waveform generator: one Q16 level per sample beat, one beat per cycle sustained
// while out_ready_i holds high. After reset the quarter-wave sine table is computed into
// RAM; in_ready_o stays low until then, config writes are taken throughout. Phase, prior
// phase, held random value and noise LFSR update at the accept edge, so samples follow
// each other with no gap; the table RAM read sits in the second stage and the depth
// multiply in the fourth.
// Depends on lfo_pkg, lfo_ram, lfo_sine_fill.
module lfo_waveform_generator #(
  parameter int unsigned SINE_TABLE_DEPTH = lfo_pkg::SINE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        restart_i,
  input  logic        block_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [16:0] lfo_level_o,
  output logic        block_last_o
);

  localparam int unsigned AW = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned DW = $clog2(SINE_TABLE_DEPTH + 1);

  // config registers
  logic [2:0]  shape_q;
  logic [31:0] inc_q;
  logic [31:0] ofs_q;
  logic [16:0] depth_q;

  // oscillator state
  logic [31:0] acc_q, prior_q;
  logic [16:0] held_q;
  logic [15:0] lfsr_q;

  // pipeline
  logic        a_vld_q, b_vld_q, c_vld_q, o_vld_q;
  logic [31:0] a_p_q;
  logic [16:0] a_held_q;
  logic [2:0]  a_shape_q;
  logic        a_last_q;
  logic        b_sine_q, b_odd0_q, b_neg_q, b_last_q;
  logic [16:0] b_other_q;
  logic [16:0] c_v_q;
  logic        c_last_q;
  logic [16:0] o_level_q;
  logic        o_last_q;

  logic o_free, c_mv, c_free, b_mv, b_free, a_mv, a_free, accept;

  // table fill and RAM
  logic          fill_done, ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [15:0]   ram_wdata, ram_rdata;

  lfo_sine_fill #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_fill (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_o  (ram_we),
    .wr_addr_o(ram_waddr),
    .wr_data_o(ram_wdata),
    .done_o   (fill_done)
  );

  lfo_ram #(
    .WIDTH(16),
    .DEPTH(SINE_TABLE_DEPTH)
  ) u_sine_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // per-stage flow control
  assign o_free     = !o_vld_q || out_ready_i;
  assign c_mv       = c_vld_q && o_free;
  assign c_free     = !c_vld_q || c_mv;
  assign b_mv       = b_vld_q && c_free;
  assign b_free     = !b_vld_q || b_mv;
  assign a_mv       = a_vld_q && b_free;
  assign a_free     = !a_vld_q || a_mv;
  assign in_ready_o = a_free && fill_done;
  assign accept     = in_valid_i && in_ready_o;
  assign ram_re     = a_mv;

  // ---- config port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q <= lfo_pkg::SHAPE_SINE;
      inc_q   <= lfo_pkg::PHASE_INC_RST;
      ofs_q   <= '0;
      depth_q <= lfo_pkg::FULL_LEVEL;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lfo_pkg::CFG_WAVE_SHAPE: shape_q <= cfg_data_i[2:0];
        lfo_pkg::CFG_PHASE_INC:  inc_q   <= cfg_data_i;
        lfo_pkg::CFG_PHASE_OFS:  ofs_q   <= cfg_data_i;
        lfo_pkg::CFG_MOD_DEPTH:  depth_q <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  // ---- accept stage: phase and random state update
  logic [31:0] acc_eff, prior_eff, phase;
  logic [16:0] held_eff, held_d;
  logic [15:0] lfsr_step, lfsr_d;
  logic        wrap;

  always_comb begin
    acc_eff   = restart_i ? 32'd0 : acc_q;
    prior_eff = restart_i ? 32'd0 : prior_q;
    held_eff  = restart_i ? lfo_pkg::HALF_LEVEL : held_q;
    phase     = acc_eff + ofs_q;
    wrap      = (shape_q == lfo_pkg::SHAPE_RANDOM) && (phase < prior_eff);
    lfsr_step = lfo_pkg::lfsr_next(lfsr_q);
    lfsr_d    = wrap ? lfsr_step : lfsr_q;
    held_d    = wrap ? {1'b0, lfsr_step} : held_eff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      prior_q <= '0;
      held_q  <= lfo_pkg::HALF_LEVEL;
      lfsr_q  <= lfo_pkg::LFSR_SEED;
    end else if (accept) begin
      acc_q   <= acc_eff + inc_q;
      prior_q <= phase;
      held_q  <= held_d;
      lfsr_q  <= lfsr_d;
    end
  end

  // ---- stage a: table address and non-sine shapes
  logic [29+DW:0] idx_prod;
  logic [AW-1:0]  tbl_idx;
  logic           idx_zero;
  logic [31:0]    neg_p;
  logic [16:0]    other_v;
  logic           use_sine;

  always_comb begin
    idx_prod  = (30 + DW)'(a_p_q[29:0]) * (30 + DW)'(SINE_TABLE_DEPTH);
    tbl_idx   = idx_prod[30 +: AW];
    idx_zero  = (tbl_idx == '0);
    // odd quadrants run the table backwards
    ram_raddr = (a_p_q[30] && !idx_zero) ? AW'(SINE_TABLE_DEPTH) - tbl_idx : tbl_idx;
    neg_p     = 32'd0 - a_p_q;
    use_sine  = 1'b0;
    case (a_shape_q)
      lfo_pkg::SHAPE_TRI: begin
        other_v = a_p_q[31] ? neg_p[31:15] : a_p_q[31:15];
      end
      lfo_pkg::SHAPE_SAW: begin
        other_v = {1'b0, a_p_q[31:16]};
      end
      lfo_pkg::SHAPE_SQUARE: begin
        other_v = a_p_q[31] ? 17'd0 : lfo_pkg::FULL_LEVEL;
      end
      lfo_pkg::SHAPE_RANDOM: begin
        other_v = a_held_q;
      end
      default: begin
        other_v  = '0;
        use_sine = 1'b1;
      end
    endcase
  end

  // ---- stage b: sine from table data
  logic [15:0] sine_s;
  logic [16:0] sine_sum;
  logic [15:0] sine_half;
  logic [16:0] wave_v;

  always_comb begin
    sine_s    = b_odd0_q ? 16'hFFFF : ram_rdata;
    sine_sum  = {1'b0, sine_s} + 17'd1;
    sine_half = sine_sum[16:1];
    if (!b_sine_q) begin
      wave_v = b_other_q;
    end else if (b_neg_q) begin
      wave_v = lfo_pkg::HALF_LEVEL - {1'b0, sine_half};
    end else begin
      wave_v = lfo_pkg::HALF_LEVEL + {1'b0, sine_half};
    end
  end

  // ---- stage c: pull toward one half by depth
  logic [16:0] depth_sat, depth_inv;
  logic [33:0] lvl_prod;
  logic [32:0] lvl_sum;

  always_comb begin
    depth_sat = (depth_q > lfo_pkg::FULL_LEVEL) ? lfo_pkg::FULL_LEVEL : depth_q;
    depth_inv = lfo_pkg::FULL_LEVEL - depth_sat;
    lvl_prod  = 34'(c_v_q) * 34'(depth_sat);
    lvl_sum   = lvl_prod[32:0] + {1'b0, depth_inv, 15'd0} + 33'(lfo_pkg::HALF_LEVEL);
  end

  // ---- pipeline registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else begin
      if (a_free) begin
        a_vld_q <= accept;
      end
      if (b_free) begin
        b_vld_q <= a_mv;
      end
      if (c_free) begin
        c_vld_q <= b_mv;
      end
      if (o_free) begin
        o_vld_q <= c_mv;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_p_q     <= phase;
      a_held_q  <= held_d;
      a_shape_q <= shape_q;
      a_last_q  <= block_end_i;
    end
    if (a_mv) begin
      b_sine_q  <= use_sine;
      b_odd0_q  <= a_p_q[30] && idx_zero;
      b_neg_q   <= a_p_q[31];
      b_other_q <= other_v;
      b_last_q  <= a_last_q;
    end
    if (b_mv) begin
      c_v_q    <= wave_v;
      c_last_q <= b_last_q;
    end
    if (c_mv) begin
      o_level_q <= lvl_sum[32:16];
      o_last_q  <= c_last_q;
    end
  end

  assign out_valid_o  = o_vld_q;
  assign lfo_level_o  = o_level_q;
  assign block_last_o = o_last_q;

  // ---- assertions
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (lfo_level_o <= lfo_pkg::FULL_LEVEL))
    else $error("level above full scale");

  a_no_write_after_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_done |-> !ram_we)
    else $error("sine RAM written after fill finished");

  a_rdata_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_vld_q && !b_mv) |=> $stable(ram_rdata))
    else $error("table data lost while stage b stalled");

  a_restart_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && restart_i) |=> (acc_q == $past(inc_q)))
    else $error("phase not cleared on restart");

  a_lfsr_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lfsr_q != 16'd0)
    else $error("noise LFSR stuck at zero");

endmodule

// File: hw/rtl/lfo_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module lfo_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/lfo_sine_fill.sv
// Sequencer that computes the quarter-wave sine table after reset and writes it to RAM.
// Each entry: nested Taylor series in Q30 on a shared set of multipliers.
// Depends on lfo_pkg.
module lfo_sine_fill #(
  parameter int unsigned SINE_TABLE_DEPTH = lfo_pkg::SINE_DEPTH_DEF,
  localparam int unsigned AW = $clog2(SINE_TABLE_DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  output logic          wr_en_o,
  output logic [AW-1:0] wr_addr_o,
  output logic [15:0]   wr_data_o,
  output logic          done_o
);

  // x(i) = floor(i * HALF_PI / DEPTH), tracked as quotient plus remainder
  localparam logic [30:0] X_STEP_Q = 31'(lfo_pkg::Q30_HALF_PI / SINE_TABLE_DEPTH);
  localparam logic [AW:0] X_STEP_R = (AW + 1)'(lfo_pkg::Q30_HALF_PI % SINE_TABLE_DEPTH);
  localparam logic [AW:0] DEPTH_W  = (AW + 1)'(SINE_TABLE_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(SINE_TABLE_DEPTH - 1);
  localparam logic [2:0] LAST_TERM = 3'(lfo_pkg::NUM_TERMS - 1);

  lfo_pkg::fill_state_e state_q, state_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [30:0]   x_q, x_d;
  logic [AW:0]   xr_q, xr_d;
  logic [2:0]    term_q, term_d;
  logic [31:0]   x2_q, x2_d;
  logic [30:0]   t_q, t_d;
  logic [31:0]   a_q, a_d;
  logic [31:0]   qe_q, qe_d;
  logic [30:0]   s_q, s_d;

  logic [61:0] x_sq;
  logic [62:0] xt_prod;
  logic [63:0] rec_prod;
  logic [38:0] chk_prod;
  logic [31:0] rem;
  logic [31:0] quot;
  logic [61:0] s_prod;
  logic [47:0] v_sum;
  logic [17:0] v_raw;
  logic [AW:0] xr_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lfo_pkg::FILL_X2;
      idx_q   <= '0;
      x_q     <= '0;
      xr_q    <= '0;
      term_q  <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      x_q     <= x_d;
      xr_q    <= xr_d;
      term_q  <= term_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x2_q <= x2_d;
    t_q  <= t_d;
    a_q  <= a_d;
    qe_q <= qe_d;
    s_q  <= s_d;
  end

  // datapath, one multiplier used per state
  always_comb begin
    x_sq     = 62'(x_q) * 62'(x_q);
    xt_prod  = 63'(x2_q) * 63'(t_q);
    rec_prod = 64'(a_q) * 64'(lfo_pkg::TERM_RECIP[term_q]);
    chk_prod = 39'(qe_q) * 39'(lfo_pkg::TERM_DIV[term_q]);
    rem      = a_q - chk_prod[31:0];
    quot     = (rem >= 32'(lfo_pkg::TERM_DIV[term_q])) ? qe_q + 32'd1 : qe_q;
    s_prod   = 62'(x_q) * 62'(t_q);
    v_sum    = 48'(s_q) * 48'd65535 + lfo_pkg::Q30_ROUND;
    v_raw    = v_sum[47:30];
    xr_sum   = xr_q + X_STEP_R;
  end

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    x_d       = x_q;
    xr_d      = xr_q;
    term_d    = term_q;
    x2_d      = x2_q;
    t_d       = t_q;
    a_d       = a_q;
    qe_d      = qe_q;
    s_d       = s_q;
    wr_en_o   = 1'b0;
    wr_data_o = (v_raw > 18'd65535) ? 16'hFFFF : v_raw[15:0];
    case (state_q)
      lfo_pkg::FILL_X2: begin
        x2_d    = x_sq[61:30];
        t_d     = lfo_pkg::Q30_ONE;
        term_d  = '0;
        state_d = lfo_pkg::FILL_MUL;
      end
      lfo_pkg::FILL_MUL: begin
        a_d     = xt_prod[61:30];
        state_d = lfo_pkg::FILL_REC;
      end
      lfo_pkg::FILL_REC: begin
        qe_d    = 32'(rec_prod >> lfo_pkg::TERM_SHIFT[term_q]);
        state_d = lfo_pkg::FILL_FIX;
      end
      lfo_pkg::FILL_FIX: begin
        t_d = lfo_pkg::Q30_ONE - quot[30:0];
        if (term_q == LAST_TERM) begin
          state_d = lfo_pkg::FILL_S;
        end else begin
          term_d  = term_q + 3'd1;
          state_d = lfo_pkg::FILL_MUL;
        end
      end
      lfo_pkg::FILL_S: begin
        s_d     = s_prod[60:30];
        state_d = lfo_pkg::FILL_V;
      end
      lfo_pkg::FILL_V: begin
        wr_en_o = 1'b1;
        if (idx_q == LAST_IDX) begin
          state_d = lfo_pkg::FILL_DONE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = lfo_pkg::FILL_X2;
          if (xr_sum >= DEPTH_W) begin
            x_d  = x_q + X_STEP_Q + 31'd1;
            xr_d = xr_sum - DEPTH_W;
          end else begin
            x_d  = x_q + X_STEP_Q;
            xr_d = xr_sum;
          end
        end
      end
      lfo_pkg::FILL_DONE: begin
        state_d = lfo_pkg::FILL_DONE;
      end
      default: begin
        state_d = lfo_pkg::FILL_X2;
      end
    endcase
  end

  assign wr_addr_o = idx_q;
  assign done_o    = (state_q == lfo_pkg::FILL_DONE);

endmodule

// File: bench/lfo_checker.sv
// Scoreboard for the LFO waveform generator: watches the register port and both beat channels,
// predicts each Q16 level and compares it field by field in order.
// Depends on lfo_pkg.
module lfo_checker
  import lfo_pkg::*;
#(
  parameter int unsigned SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        restart_i,
  input  logic        block_end_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [16:0] lfo_level_i,
  input  logic        block_last_i,
  output int unsigned mismatch_o,
  output int unsigned pending_o,
  output int unsigned checked_o,
  output int unsigned refresh_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [16:0] level;
    logic        block_last;
  } lfo_sample_t;

  logic [15:0] quarter_sine [SINE_TABLE_DEPTH];

  // shadow registers and generator state
  logic [2:0]  shape_q;
  logic [31:0] step_q;
  logic [31:0] offset_q;
  logic [16:0] depth_q;
  logic [31:0] accum_q;
  logic [31:0] last_phase_q;
  logic [16:0] held_q;
  logic [15:0] noise_q;

  lfo_sample_t levels_due [$];
  int unsigned mismatches = 0;
  int unsigned pending = 0;
  int unsigned checked = 0;
  int unsigned refreshes = 0;

  assign mismatch_o = mismatches;
  assign pending_o  = pending;
  assign checked_o  = checked;
  assign refresh_o  = refreshes;

  function automatic logic [63:0] taylor_fold(input logic [63:0] x2, input logic [63:0] t,
                                              input int unsigned div);
    return (64'd1 << 30) - (((x2 * t) >> 30) / 64'(div));
  endfunction

  // round(65535 * sin(pi/2 * i / depth)) through a nested Q30 series
  function automatic logic [15:0] sine_point(input int unsigned i);
    int unsigned divs [5] = '{110, 72, 42, 20, 6};
    logic [63:0] x, x2, t, s, v;
    x  = (64'(i) * 64'(Q30_HALF_PI)) / 64'(SINE_TABLE_DEPTH);
    x2 = (x * x) >> 30;
    t  = 64'd1 << 30;
    for (int k = 0; k < 5; k++) begin
      t = taylor_fold(x2, t, divs[k]);
    end
    s = (x * t) >> 30;
    v = (s * 64'd65535 + (64'd1 << 29)) >> 30;
    return (v > 64'd65535) ? 16'hFFFF : v[15:0];
  endfunction

  initial begin
    for (int unsigned i = 0; i < SINE_TABLE_DEPTH; i++) begin
      quarter_sine[i] = sine_point(i);
    end
  end

  // one sample tick: level for this beat, then advance the phase
  function automatic logic [16:0] next_level(input logic restart);
    logic [31:0] p;
    logic [63:0] w, d, lvl, idx;
    logic [15:0] s;
    logic [16:0] half;
    if (restart) begin
      accum_q      = '0;
      last_phase_q = '0;
      held_q       = HALF_LEVEL;
    end
    p = accum_q + offset_q;
    case (shape_q)
      SHAPE_TRI: w = p[31] ? ((64'h1_0000_0000 - 64'(p)) >> 15) : 64'(p >> 15);
      SHAPE_SAW: w = 64'(p >> 16);
      SHAPE_SQUARE: w = p[31] ? 64'd0 : 64'(FULL_LEVEL);
      SHAPE_RANDOM: begin
        // new value only when the offset phase wraps
        if (p < last_phase_q) begin
          noise_q = {1'b0, noise_q[15:1]} ^ (noise_q[0] ? LFSR_TAPS : 16'h0000);
          held_q  = {1'b0, noise_q};
          refreshes++;
        end
        w = 64'(held_q);
      end
      default: begin
        idx = (64'(p[29:0]) * 64'(SINE_TABLE_DEPTH)) >> 30;
        if (!p[30]) begin
          s = quarter_sine[idx];
        end else if (idx == 64'd0) begin
          s = 16'hFFFF;
        end else begin
          s = quarter_sine[64'(SINE_TABLE_DEPTH) - idx];
        end
        half = (17'(s) + 17'd1) >> 1;
        w = p[31] ? 64'(HALF_LEVEL - half) : 64'(HALF_LEVEL + half);
      end
    endcase
    last_phase_q = p;
    d = (depth_q > FULL_LEVEL) ? 64'(FULL_LEVEL) : 64'(depth_q);
    lvl = (w * d + 64'd32768 * (64'd65536 - d) + 64'd32768) >> 16;
    accum_q = accum_q + step_q;
    return (lvl > 64'd65536) ? FULL_LEVEL : lvl[16:0];
  endfunction

  task automatic flag(input string what, input longint unsigned want, input longint unsigned got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lfo_sample_t due;
    if (!rst_ni) begin
      shape_q      = SHAPE_SINE;
      step_q       = PHASE_INC_RST;
      offset_q     = '0;
      depth_q      = FULL_LEVEL;
      accum_q      = '0;
      last_phase_q = '0;
      held_q       = HALF_LEVEL;
      noise_q      = LFSR_SEED;
      levels_due.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WAVE_SHAPE: shape_q  = cfg_data_i[2:0];
          CFG_PHASE_INC:  step_q   = cfg_data_i;
          CFG_PHASE_OFS:  offset_q = cfg_data_i;
          CFG_MOD_DEPTH:  depth_q  = cfg_data_i[16:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        checked++;
        if (levels_due.size() == 0) begin
          flag("level (no beat outstanding)", 0, lfo_level_i);
        end else begin
          due = levels_due.pop_front();
          if (lfo_level_i !== due.level) begin
            flag("lfo_level", due.level, lfo_level_i);
          end
          if (block_last_i !== due.block_last) begin
            flag("block_last", due.block_last, block_last_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        due.level      = next_level(restart_i);
        due.block_last = block_end_i;
        levels_due.push_back(due);
      end
    end
    pending = levels_due.size();
  end

endmodule

// File: bench/tb_lfo_waveform_generator.sv
// Top of the LFO waveform generator bench: clock, reset, register phases, bursty sample
// beats and a stalling output side; verdict comes from lfo_checker.
// Depends on lfo_pkg, lfo_checker and the generator RTL.
module tb_lfo_waveform_generator;
  import lfo_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDLE_LIMIT = 80000;  // covers the table fill after reset
  localparam int unsigned LONG_HOLD  = 300;
  localparam int unsigned RAND_PHASES = 12;
  localparam int unsigned PHASE_BEATS = 60;

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = CFG_WAVE_SHAPE;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        restart = 1'b0;
  logic        block_end = 1'b0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [16:0] lfo_level;
  logic        block_last;

  int unsigned mismatches, pending, checked, refreshes;
  int unsigned beats_sent = 0;
  int unsigned restarts_sent = 0;
  int unsigned settings = 0;
  int unsigned burst_left = 0;
  int unsigned hold_requests = 0;
  int unsigned quiet_cycles = 0;

  lfo_waveform_generator uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .restart_i    (restart),
    .block_end_i  (block_end),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .lfo_level_o  (lfo_level),
    .block_last_o (block_last)
  );

  lfo_checker scoreboard (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .restart_i    (restart),
    .block_end_i  (block_end),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .lfo_level_i  (lfo_level),
    .block_last_i (block_last),
    .mismatch_o   (mismatches),
    .pending_o    (pending),
    .checked_o    (checked),
    .refresh_o    (refreshes)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
      $display("** lfo_waveform_generator: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // output side: random segments of always-ready, mostly-ready, mostly-stalled and toggling,
  // plus a long hold whenever the stimulus asks for one
  initial begin : drain_side
    int unsigned seg_left = 0;
    int unsigned mode = 0;
    int unsigned stall_left = 0;
    int unsigned holds_served = 0;
    forever begin
      @(posedge clk_i);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode = $urandom_range(0, 3);
          seg_left = $urandom_range(8, 64);
        end
        seg_left--;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ~out_ready;
        endcase
      end
    end
  end

  // writes all four registers on consecutive edges; called only while idle
  task automatic program_regs(input logic [2:0] shape, input logic [31:0] step,
                              input logic [31:0] offset, input logic [31:0] depth);
    logic [28:0] junk;
    junk = 29'($urandom());
    cfg_we <= 1'b1;
    cfg_idx <= CFG_WAVE_SHAPE;
    cfg_data <= {junk, shape};
    @(posedge clk_i);
    cfg_idx <= CFG_PHASE_INC;
    cfg_data <= step;
    @(posedge clk_i);
    cfg_idx <= CFG_PHASE_OFS;
    cfg_data <= offset;
    @(posedge clk_i);
    cfg_idx <= CFG_MOD_DEPTH;
    cfg_data <= depth;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    settings++;
  endtask

  // one sample beat; bursts of random length separated by random gaps
  task automatic push_sample(input logic rs, input logic be);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid <= 1'b1;
    restart <= rs;
    block_end <= be;
    do @(posedge clk_i); while (!in_ready);
    burst_left--;
    beats_sent++;
    if (rs) begin
      restarts_sent++;
    end
  endtask

  // drop valid, wait for every outstanding level, then let the pipeline drain
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_step();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(1, 1 << 20);
      2: return {8'($urandom_range(1, 255)), 24'h0};
      3: return 32'hFFFF_FFFF - $urandom_range(0, 1 << 20);
      4: return PHASE_INC_RST;
      default: return ($urandom_range(0, 3) == 0) ? 32'd0 : 32'd1;
    endcase
  endfunction

  function automatic logic [31:0] pick_depth();
    case ($urandom_range(0, 3))
      0: return 32'd0;
      1: return 32'(FULL_LEVEL);
      2: return $urandom_range(0, 65536);
      default: return $urandom();
    endcase
  endfunction

  initial begin : stimulus
    logic [2:0] shape;
    repeat (9) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // register reset values, restart and block_end in all four combinations
    push_sample(1'b1, 1'b0);
    push_sample(1'b0, 1'b1);
    push_sample(1'b0, 1'b0);
    push_sample(1'b1, 1'b1);
    settle();

    // triangle from its peak through the quadrant boundaries
    program_regs(SHAPE_TRI, 32'h4000_0000, 32'h8000_0000, 32'(FULL_LEVEL));
    push_sample(1'b1, 1'b0);
    repeat (3) push_sample(1'b0, 1'b0);
    settle();

    // sine at each quadrant start; odd quadrants start at the table's missing top entry
    program_regs(SHAPE_SINE, 32'h4000_0000, 32'h0, 32'(FULL_LEVEL));
    push_sample(1'b1, 1'b1);
    repeat (3) push_sample(1'b0, 1'b0);
    settle();

    // square around its edge, depth above full with every upper bit set
    program_regs(SHAPE_SQUARE, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    push_sample(1'b1, 1'b0);
    repeat (2) push_sample(1'b0, 1'b1);
    settle();

    // phase steps backward, refreshing from the third tick; depth bit 17 alone leaves zero depth
    program_regs(SHAPE_RANDOM, 32'hFFFF_FFFF, 32'h0, 32'h0002_0000);
    push_sample(1'b1, 1'b0);
    repeat (3) push_sample(1'b0, 1'b0);
    settle();

    // frozen phase at the top of the saw
    program_regs(SHAPE_SAW, 32'h0, 32'hFFFF_FFFF, 32'(FULL_LEVEL));
    repeat (2) push_sample(1'b0, 1'b0);
    settle();

    // unused shape codes play as sine
    for (int code = 5; code < 8; code++) begin
      program_regs(3'(code), $urandom(), $urandom(), pick_depth());
      push_sample(1'b0, 1'b0);
      push_sample(1'b1, 1'b1);
      settle();
    end

    for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
      shape = (ph < 8) ? 3'(ph) : 3'($urandom_range(0, 7));
      if (shape == SHAPE_RANDOM) begin
        program_regs(shape, $urandom(), $urandom(), pick_depth());
      end else begin
        program_regs(shape, pick_step(), $urandom(), pick_depth());
      end
      if (ph == 3) begin
        hold_requests++;  // output side stops while beats keep coming
      end
      for (int unsigned n = 0; n < PHASE_BEATS; n++) begin
        push_sample($urandom_range(0, 19) == 0, $urandom_range(0, 7) == 0);
      end
      settle();
    end

    repeat (10) @(posedge clk_i);
    $display("covered %0d sample beats (%0d restarts) over %0d register settings, all shape codes",
             beats_sent, restarts_sent, settings);
    $display("checked %0d levels, %0d random-hold refreshes, one %0d-cycle output hold",
             checked, refreshes, LONG_HOLD);
    if (mismatches == 0 && pending == 0) begin
      $display("** lfo_waveform_generator: PASSED **");
    end else begin
      $display("%0d mismatches, %0d levels outstanding", mismatches, pending);
      $display("** lfo_waveform_generator: FAILED **");
    end
    $finish;
  end

endmodule

// File: lfo_waveform_generator.f
hw/rtl/lfo_pkg.sv
hw/rtl/lfo_ram.sv
hw/rtl/lfo_sine_fill.sv
hw/rtl/lfo_waveform_generator.sv
bench/lfo_checker.sv
bench/tb_lfo_waveform_generator.sv
